// ----- rtl/fism_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the frequent-items summary merge block.
// No dependencies.
package fism_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ORDER    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [31:0] item_key;
        logic [31:0] item_count;
        logic        last_of_batch;
    } fism_in_t;

    typedef struct packed {
        logic [31:0] entry_key;
        logic [31:0] entry_count;
        logic [5:0]  table_size;
        logic [1:0]  status;
        logic        last_entry;
    } fism_out_t;

    // per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;       // take neighbor's entry
        logic clr_rank;    // entry arriving fresh: rank counter starts at zero
        logic rank_en;     // count broadcast entries whose count is above this entry's
        logic bcast_valid;
    } fism_cell_ctrl_t;

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_ERR   = 9'b000000010,
        S_MRD   = 9'b000000100,
        S_MCMP  = 9'b000001000,
        S_RANK  = 9'b000010000,
        S_MIN   = 9'b000100000,
        S_PRUNE = 9'b001000000,
        S_ERD   = 9'b010000000,
        S_EPUT  = 9'b100000000
    } fism_state_t;

endpackage

// ----- rtl/fism_cell.sv -----
`timescale 1ns / 1ps
// One cell of the merge chain: holds one (key, count) entry and its rank.
// Depends on fism_pkg.
module fism_cell
    import fism_pkg::*;
#(
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 32,
    parameter int RANK_BITS  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fism_cell_ctrl_t       ctrl,
    input  logic [COUNT_BITS-1:0] bcast_count,
    input  logic                  prev_valid,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [COUNT_BITS-1:0] prev_count,
    input  logic [RANK_BITS-1:0]  prev_rank,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [COUNT_BITS-1:0] count,
    output logic [RANK_BITS-1:0]  rank
);

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [RANK_BITS-1:0]  rank_reg;
    logic [RANK_BITS-1:0]  rank_next;
    logic                  above;

    // rank counts the entries whose count is above this one
    assign above = ctrl.rank_en && ctrl.bcast_valid && prev_valid && (bcast_count > prev_count);

    always_comb begin
        if (ctrl.clr_rank) begin
            rank_next = '0;
        end else begin
            rank_next = prev_rank + RANK_BITS'(above);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            key_reg   <= prev_key;
            count_reg <= prev_count;
            rank_reg  <= rank_next;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign count = count_reg;
    assign rank  = rank_reg;

endmodule

// ----- rtl/frequent_items_summary_merge.sv -----
`timescale 1ns / 1ps
// Top level of the Misra-Gries frequent-items summary with batch merge.
// Depends on fism_pkg and fism_cell.
//
//  channel | ports                         | direction | moves
//  --------+-------------------------------+-----------+---------------------
//  input   | s_valid s_ready s_item        | in        | one batch entry
//  result  | m_valid m_ready m_item        | out       | one table entry
//  config  | cfg_valid cfg_ready cfg_data  | in        | capacity register
//
// Batch entries are taken one a cycle. The last entry of an error-free batch
// starts a sequence: merge (a read and a compare state per chain slot,
// N = CAPACITY + BATCH_DEPTH slots), rank and minimum passes (one rotation of
// the chain each), a prune pass, then a read and an output state per result,
// held while m_ready is low. No item is taken during the sequence. Reset
// clears control state only; stores hold data behind fill counts.
module frequent_items_summary_merge
    import fism_pkg::*;
#(
    parameter int CAPACITY    = 32,
    parameter int BATCH_DEPTH = 32,
    parameter int KEY_BITS    = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  fism_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output fism_out_t m_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [5:0] cfg_data
);

    localparam int N   = CAPACITY + BATCH_DEPTH;
    localparam int AW  = $clog2(N + 1);
    localparam int CFW = $clog2(CAPACITY + 1);
    localparam int BFW = $clog2(BATCH_DEPTH + 1);
    localparam int CIW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BIW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;

    fism_state_t state_reg, state_next;

    logic [5:0]            capacity_reg;
    logic [CFW-1:0]        table_fill_reg, table_fill_next;
    logic [BFW-1:0]        batch_fill_reg, batch_fill_next;
    logic [1:0]            err_reg, err_next;
    logic [KEY_BITS-1:0]   last_key_reg, last_key_next;
    logic [CFW-1:0]        a_reg, a_next;
    logic [BFW-1:0]        b_reg, b_next;
    logic [AW-1:0]         n_reg, n_next;
    logic [AW-1:0]         pass_reg, pass_next;
    logic [CFW-1:0]        wr_reg, wr_next;
    logic [CFW-1:0]        e_reg, e_next;
    logic [COUNT_BITS-1:0] d_reg, d_next;
    logic                  m_valid_reg, m_valid_next;
    fism_out_t             m_item_reg, m_item_next;

    // stores
    logic [KEY_BITS-1:0]   t_keys [CAPACITY];
    logic [COUNT_BITS-1:0] t_counts [CAPACITY];
    logic [KEY_BITS-1:0]   b_keys [BATCH_DEPTH];
    logic [COUNT_BITS-1:0] b_counts [BATCH_DEPTH];
    logic [KEY_BITS-1:0]   t_rd_key;
    logic [COUNT_BITS-1:0] t_rd_count;
    logic [KEY_BITS-1:0]   b_rd_key;
    logic [COUNT_BITS-1:0] b_rd_count;
    logic [CFW-1:0]        t_raddr;
    logic                  t_we, b_we;

    // chain
    logic                  c_valid [N];
    logic [KEY_BITS-1:0]   c_key [N];
    logic [COUNT_BITS-1:0] c_count [N];
    logic [AW-1:0]         c_rank [N];
    logic                  in_valid;
    logic [KEY_BITS-1:0]   in_key;
    logic [COUNT_BITS-1:0] in_count;
    logic [AW-1:0]         in_rank;
    fism_cell_ctrl_t       ctrl;
    logic                  rotate;
    logic                  push_valid;
    logic [KEY_BITS-1:0]   push_key;
    logic [COUNT_BITS-1:0] push_count;

    logic                  s_fire, out_free, pass_done;
    logic [KEY_BITS-1:0]   new_key;
    logic [COUNT_BITS-1:0] new_count;
    logic [6:0]            cap_w;
    logic [CFW-1:0]        cap_eff;
    logic                  ta_ok, tb_ok, take_t, take_b;
    logic [COUNT_BITS:0]   sum_w;
    logic [COUNT_BITS-1:0] sum_sat;
    logic [COUNT_BITS-1:0] d_eff;
    logic                  keep;

    assign s_ready   = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign pass_done = (pass_reg == AW'(N - 1));

    assign new_key   = KEY_BITS'(s_item.item_key);
    assign new_count = COUNT_BITS'(s_item.item_count);

    assign cap_w   = {1'b0, capacity_reg};
    assign cap_eff = (cap_w == 7'd0) ? CFW'(1) :
                     (cap_w > 7'(CAPACITY)) ? CFW'(CAPACITY) : CFW'(cap_w);

    // merge step
    assign ta_ok  = (a_reg < table_fill_reg);
    assign tb_ok  = (b_reg < batch_fill_reg);
    assign take_t = ta_ok && (!tb_ok || (t_rd_key < b_rd_key));
    assign take_b = tb_ok && (!ta_ok || (b_rd_key < t_rd_key));
    assign sum_w   = {1'b0, t_rd_count} + {1'b0, b_rd_count};
    assign sum_sat = sum_w[COUNT_BITS] ? '1 : sum_w[COUNT_BITS-1:0];

    always_comb begin
        push_valid = ta_ok || tb_ok;
        if (take_t) begin
            push_key   = t_rd_key;
            push_count = t_rd_count;
        end else if (take_b) begin
            push_key   = b_rd_key;
            push_count = b_rd_count;
        end else begin
            push_key   = t_rd_key;
            push_count = sum_sat;
        end
    end

    // pruning threshold is the (cap+1)-th largest count when over capacity
    assign d_eff = (n_reg > AW'(cap_eff)) ? d_reg : '0;
    assign keep  = c_valid[N-1] && (c_count[N-1] > d_eff);

    // chain control
    assign rotate = (state_reg == S_RANK) || (state_reg == S_MIN);
    always_comb begin
        ctrl.shift       = (state_reg == S_MCMP) || rotate || (state_reg == S_PRUNE);
        ctrl.clr_rank    = (state_reg == S_MCMP);
        ctrl.rank_en     = (state_reg == S_RANK);
        ctrl.bcast_valid = c_valid[N-1];
        if (rotate) begin
            in_valid = c_valid[N-1];
            in_key   = c_key[N-1];
            in_count = c_count[N-1];
            in_rank  = c_rank[N-1];
        end else begin
            in_valid = (state_reg == S_MCMP) && push_valid;
            in_key   = push_key;
            in_count = push_count;
            in_rank  = '0;
        end
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_chain
        if (gi == 0) begin : g_first
            fism_cell #(
                .KEY_BITS  (KEY_BITS),
                .COUNT_BITS(COUNT_BITS),
                .RANK_BITS (AW)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .bcast_count(c_count[N-1]),
                .prev_valid (in_valid),
                .prev_key   (in_key),
                .prev_count (in_count),
                .prev_rank  (in_rank),
                .valid      (c_valid[gi]),
                .key        (c_key[gi]),
                .count      (c_count[gi]),
                .rank       (c_rank[gi])
            );
        end else begin : g_rest
            fism_cell #(
                .KEY_BITS  (KEY_BITS),
                .COUNT_BITS(COUNT_BITS),
                .RANK_BITS (AW)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .bcast_count(c_count[N-1]),
                .prev_valid (c_valid[gi-1]),
                .prev_key   (c_key[gi-1]),
                .prev_count (c_count[gi-1]),
                .prev_rank  (c_rank[gi-1]),
                .valid      (c_valid[gi]),
                .key        (c_key[gi]),
                .count      (c_count[gi]),
                .rank       (c_rank[gi])
            );
        end
    end

    // memories
    assign t_raddr = (state_reg == S_ERD || state_reg == S_EPUT) ? e_reg : a_reg;
    assign t_we    = (state_reg == S_PRUNE) && keep;
    assign b_we    = s_fire && (err_next == STATUS_OK) && (err_reg == STATUS_OK);

    always_ff @(posedge aclk) begin
        if (t_we) begin
            t_keys[wr_reg[CIW-1:0]]   <= c_key[N-1];
            t_counts[wr_reg[CIW-1:0]] <= c_count[N-1] - d_eff;
        end
        t_rd_key   <= t_keys[t_raddr[CIW-1:0]];
        t_rd_count <= t_counts[t_raddr[CIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_keys[batch_fill_reg[BIW-1:0]]   <= new_key;
            b_counts[batch_fill_reg[BIW-1:0]] <= new_count;
        end
        b_rd_key   <= b_keys[b_reg[BIW-1:0]];
        b_rd_count <= b_counts[b_reg[BIW-1:0]];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        table_fill_next = table_fill_reg;
        batch_fill_next = batch_fill_reg;
        err_next        = err_reg;
        last_key_next   = last_key_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        n_next          = n_reg;
        pass_next       = pass_reg;
        wr_next         = wr_reg;
        e_next          = e_reg;
        d_next          = d_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;

        unique case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (err_reg == STATUS_OK) begin
                        if (new_count == '0 ||
                            (batch_fill_reg != '0 && new_key <= last_key_reg)) begin
                            err_next = STATUS_ORDER;
                        end else if (batch_fill_reg >= BFW'(BATCH_DEPTH)) begin
                            err_next = STATUS_OVERFLOW;
                        end else begin
                            batch_fill_next = batch_fill_reg + BFW'(1);
                            last_key_next   = new_key;
                        end
                    end
                    if (s_item.last_of_batch) begin
                        if (err_next != STATUS_OK) begin
                            state_next = S_ERR;
                        end else begin
                            state_next = S_MRD;
                            a_next     = '0;
                            b_next     = '0;
                            n_next     = '0;
                            pass_next  = '0;
                        end
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{entry_key: '0, entry_count: '0,
                                     table_size: 6'(table_fill_reg),
                                     status: err_reg, last_entry: 1'b1};
                    batch_fill_next = '0;
                    err_next        = STATUS_OK;
                    state_next      = S_LOAD;
                end
            end
            S_MRD: begin
                state_next = S_MCMP;
            end
            S_MCMP: begin
                if (take_t || !take_b) begin
                    if (ta_ok) begin
                        a_next = a_reg + CFW'(1);
                    end
                end
                if (take_b || !take_t) begin
                    if (tb_ok) begin
                        b_next = b_reg + BFW'(1);
                    end
                end
                if (push_valid) begin
                    n_next = n_reg + AW'(1);
                end
                if (pass_done) begin
                    pass_next  = '0;
                    d_next     = '1;
                    state_next = S_RANK;
                end else begin
                    pass_next  = pass_reg + AW'(1);
                    state_next = S_MRD;
                end
            end
            S_RANK: begin
                pass_next = pass_reg + AW'(1);
                if (pass_done) begin
                    pass_next  = '0;
                    state_next = S_MIN;
                end
            end
            S_MIN: begin
                if (c_valid[N-1] && c_rank[N-1] <= AW'(cap_eff) && c_count[N-1] < d_reg) begin
                    d_next = c_count[N-1];
                end
                pass_next = pass_reg + AW'(1);
                if (pass_done) begin
                    pass_next  = '0;
                    wr_next    = '0;
                    state_next = S_PRUNE;
                end
            end
            S_PRUNE: begin
                if (keep) begin
                    wr_next = wr_reg + CFW'(1);
                end
                pass_next = pass_reg + AW'(1);
                if (pass_done) begin
                    pass_next       = '0;
                    table_fill_next = wr_next;
                    batch_fill_next = '0;
                    err_next        = STATUS_OK;
                    e_next          = '0;
                    state_next      = S_ERD;
                end
            end
            S_ERD: begin
                state_next = S_EPUT;
            end
            S_EPUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (table_fill_reg == '0) begin
                        m_item_next = '{entry_key: '0, entry_count: '0, table_size: '0,
                                        status: STATUS_OK, last_entry: 1'b1};
                        state_next  = S_LOAD;
                    end else begin
                        m_item_next = '{entry_key: 32'(t_rd_key),
                                        entry_count: 32'(t_rd_count),
                                        table_size: 6'(table_fill_reg),
                                        status: STATUS_OK,
                                        last_entry: (e_reg + CFW'(1) == table_fill_reg)};
                        if (e_reg + CFW'(1) == table_fill_reg) begin
                            state_next = S_LOAD;
                        end else begin
                            e_next     = e_reg + CFW'(1);
                            state_next = S_ERD;
                        end
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            capacity_reg   <= 6'd32;
            table_fill_reg <= '0;
            batch_fill_reg <= '0;
            err_reg        <= STATUS_OK;
            m_valid_reg    <= 1'b0;
            pass_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            table_fill_reg <= table_fill_next;
            batch_fill_reg <= batch_fill_next;
            err_reg        <= err_next;
            m_valid_reg    <= m_valid_next;
            pass_reg       <= pass_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_key_reg <= last_key_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        n_reg        <= n_next;
        wr_reg       <= wr_next;
        e_reg        <= e_next;
        d_reg        <= d_next;
        m_item_reg   <= m_item_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        table_fill_reg <= CFW'(CAPACITY))
        else $error("table fill above capacity");

    a_prune_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PRUNE && pass_done) |-> (wr_next <= cap_eff))
        else $error("pruned table larger than capacity");

    a_merge_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RANK) |-> (n_reg <= AW'(N)))
        else $error("merged list longer than chain");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MCMP) |=> !s_ready)
        else $error("input taken during merge");

endmodule
